>>> rtl/core/rdcm_pkg.sv
// ----------------------------------------------------------------------------
// rdcm_pkg
// Shared widths and register codes for the radial distortion coordinate map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rdcm_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int COORD_W   = 16;
  // dest - origin - center needs two more bits than a coordinate
  localparam int OFF_W     = COORD_W + 2;
  localparam int MAG_W     = COORD_W + 1;
  // squared distance, padded to an even number of bits for the root
  localparam int SQ_W      = 2 * (MAG_W + 1);
  localparam int RAD_W     = 32;
  localparam int SCALE_W   = 18;
  localparam int QUOT_W    = 40;
  localparam int OUT_W     = 32;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_RADIUS   = 3'd4,
    REG_SCALE    = 3'd5
  } cfg_reg_t;

endpackage

>>> rtl/core/rdcm_sqrt.sv
// ----------------------------------------------------------------------------
// rdcm_sqrt
// Pipelined digit-by-digit square root, one root bit per stage, with
// FRAC_BITS fraction bits in the result and a sideband carried alongside.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rdcm_sqrt #(
  parameter int FRAC_BITS = rdcm_pkg::FRAC_BITS_DEF,
  parameter int SB_W      = 1
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      en,
  input  logic                                      in_valid,
  input  logic [rdcm_pkg::SQ_W-1:0]                 in_sq,
  input  logic [SB_W-1:0]                           in_sb,
  output logic                                      out_valid,
  output logic [rdcm_pkg::SQ_W/2+FRAC_BITS-1:0]     out_root,
  output logic [SB_W-1:0]                           out_sb
);

  localparam int RW  = rdcm_pkg::SQ_W / 2 + FRAC_BITS;
  localparam int N   = RW;
  localparam int RMW = RW + 2;
  localparam int SQW = rdcm_pkg::SQ_W;

  logic            v_r    [N];
  logic [RMW-1:0]  rem_r  [N];
  logic [RW-1:0]   root_r [N];
  logic [SQW-1:0]  sq_r   [N];
  logic [SB_W-1:0] sb_r   [N];

  for (genvar j = 0; j < N; j++) begin : g_stage
    localparam int I = N - 1 - j;

    logic            v_i;
    logic [RMW-1:0]  rem_i;
    logic [RW-1:0]   root_i;
    logic [SQW-1:0]  sq_i;
    logic [SB_W-1:0] sb_i;
    logic [1:0]      pair;
    logic [SQW-1:0]  sq_nxt;
    logic [RMW-1:0]  rem_sh;
    logic [RMW-1:0]  trial;
    logic [RMW-1:0]  rem_nxt;
    logic [RW-1:0]   root_nxt;
    logic            ge;

    if (j == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = '0;
      assign root_i = '0;
      assign sq_i   = in_sq;
      assign sb_i   = in_sb;
    end else begin : g_next
      assign v_i    = v_r[j-1];
      assign rem_i  = rem_r[j-1];
      assign root_i = root_r[j-1];
      assign sq_i   = sq_r[j-1];
      assign sb_i   = sb_r[j-1];
    end

    // integer digits come from the radicand, fraction digits bring in zeros
    if (I >= FRAC_BITS) begin : g_pair
      assign pair   = sq_i[SQW-1 -: 2];
      assign sq_nxt = sq_i << 2;
    end else begin : g_zero
      assign pair   = 2'b00;
      assign sq_nxt = sq_i;
    end

    assign rem_sh   = {rem_i[RMW-3:0], pair};
    assign trial    = {root_i, 2'b01};
    assign ge       = rem_sh >= trial;
    assign rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
    assign root_nxt = {root_i[RW-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt;
        root_r[j] <= root_nxt;
        sq_r[j]   <= sq_nxt;
        sb_r[j]   <= sb_i;
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_root  = root_r[N-1];
  assign out_sb    = sb_r[N-1];

endmodule

>>> rtl/core/rdcm_div.sv
// ----------------------------------------------------------------------------
// rdcm_div
// Pipelined restoring divider, one quotient bit per stage, for a quotient
// known to fit in QUOT_W bits; a sideband travels with each transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rdcm_div #(
  parameter int SB_W = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic [rdcm_pkg::RAD_W-1:0]   in_rad,
  input  logic                         in_valid,
  input  logic [rdcm_pkg::RAD_W-1:0]   in_rem,
  input  logic [rdcm_pkg::QUOT_W-1:0]  in_lo,
  input  logic [SB_W-1:0]              in_sb,
  output logic                         out_valid,
  output logic [rdcm_pkg::QUOT_W-1:0]  out_quot,
  output logic [SB_W-1:0]              out_sb
);

  localparam int N  = rdcm_pkg::QUOT_W;
  localparam int DW = rdcm_pkg::RAD_W;

  logic            v_r   [N];
  logic [DW-1:0]   rem_r [N];
  logic [N-1:0]    lo_r  [N];
  logic [N-1:0]    q_r   [N];
  logic [SB_W-1:0] sb_r  [N];

  for (genvar j = 0; j < N; j++) begin : g_stage
    logic            v_i;
    logic [DW-1:0]   rem_i;
    logic [N-1:0]    lo_i;
    logic [N-1:0]    q_i;
    logic [SB_W-1:0] sb_i;
    logic [DW:0]     rem_sh;
    logic [DW-1:0]   rem_nxt;
    logic            ge;

    if (j == 0) begin : g_first
      assign v_i   = in_valid;
      assign rem_i = in_rem;
      assign lo_i  = in_lo;
      assign q_i   = '0;
      assign sb_i  = in_sb;
    end else begin : g_next
      assign v_i   = v_r[j-1];
      assign rem_i = rem_r[j-1];
      assign lo_i  = lo_r[j-1];
      assign q_i   = q_r[j-1];
      assign sb_i  = sb_r[j-1];
    end

    assign rem_sh  = {rem_i, lo_i[N-1]};
    assign ge      = rem_sh >= {1'b0, in_rad};
    assign rem_nxt = ge ? DW'(rem_sh - {1'b0, in_rad}) : rem_sh[DW-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= rem_nxt;
        lo_r[j]  <= lo_i << 1;
        q_r[j]   <= {q_i[N-2:0], ge};
        sb_r[j]  <= sb_i;
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_quot  = q_r[N-1];
  assign out_sb    = sb_r[N-1];

endmodule

>>> rtl/core/radial_distortion_coordinate_map_core.sv
// ----------------------------------------------------------------------------
// radial_distortion_coordinate_map_core
// Pipeline: 3 offset/square stages, one root bit per stage, 5 scale/multiply
// stages, 40 quotient stages and the output register, from input transaction
// to out_valid. Throughput: one transaction per cycle while the output buffer
// is not full; a two-entry output buffer holds results under backpressure.
// Synchronous active-low reset clears all valid bits and loads the register
// reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module radial_distortion_coordinate_map_core #(
  parameter int FRAC_BITS = rdcm_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [rdcm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rdcm_pkg::RAD_W-1:0]           cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [rdcm_pkg::COORD_W-1:0]  in_dest_x,
  input  logic signed [rdcm_pkg::COORD_W-1:0]  in_dest_y,
  input  logic                                 in_span_end,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [rdcm_pkg::OUT_W-1:0]    out_source_x,
  output logic signed [rdcm_pkg::OUT_W-1:0]    out_source_y,
  output logic                                 out_last_out
);

  localparam int COORD_W = rdcm_pkg::COORD_W;
  localparam int OFF_W   = rdcm_pkg::OFF_W;
  localparam int MAG_W   = rdcm_pkg::MAG_W;
  localparam int SQ_W    = rdcm_pkg::SQ_W;
  localparam int RAD_W   = rdcm_pkg::RAD_W;
  localparam int SCALE_W = rdcm_pkg::SCALE_W;
  localparam int QUOT_W  = rdcm_pkg::QUOT_W;
  localparam int OUT_W   = rdcm_pkg::OUT_W;

  localparam int RW   = SQ_W / 2 + FRAC_BITS;
  localparam int DIFW = ((RW > RAD_W) ? RW : RAD_W) + 1;
  localparam int TW   = SCALE_W + DIFW;
  localparam int TMW  = TW - FRAC_BITS;
  localparam int NUMW = ((TMW > RW) ? TMW : RW) + 2;
  localparam int PW   = NUMW - 1 + MAG_W;
  localparam int CMPW = (PW > RAD_W + QUOT_W) ? PW : RAD_W + QUOT_W;
  localparam int CLW  = (FRAC_BITS + 2 > SCALE_W) ? FRAC_BITS + 2 : SCALE_W;
  localparam int VW   = QUOT_W + 3;
  localparam int SBW  = 2 * OFF_W + 1;

  localparam logic signed [VW-1:0] SAT_HI = {{(VW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [VW-1:0] SAT_LO = {{(VW-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};
  localparam logic [OUT_W-1:0] OUT_MAX = SAT_HI[OUT_W-1:0];
  localparam logic [OUT_W-1:0] OUT_MIN = SAT_LO[OUT_W-1:0];

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic signed [COORD_W-1:0] origin_x_r, origin_y_r, center_x_r, center_y_r;
  logic [RAD_W-1:0]          radius_r;
  logic signed [SCALE_W-1:0] scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      center_x_r <= '0;
      center_y_r <= '0;
      radius_r   <= RAD_W'(1) << FRAC_BITS;
      scale_r    <= '0;
    end else if (cfg_we) begin
      unique case (rdcm_pkg::cfg_reg_t'(cfg_index))
        rdcm_pkg::REG_ORIGIN_X: origin_x_r <= cfg_wdata[COORD_W-1:0];
        rdcm_pkg::REG_ORIGIN_Y: origin_y_r <= cfg_wdata[COORD_W-1:0];
        rdcm_pkg::REG_CENTER_X: center_x_r <= cfg_wdata[COORD_W-1:0];
        rdcm_pkg::REG_CENTER_Y: center_y_r <= cfg_wdata[COORD_W-1:0];
        rdcm_pkg::REG_RADIUS:   radius_r   <= cfg_wdata[RAD_W-1:0];
        rdcm_pkg::REG_SCALE:    scale_r    <= cfg_wdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // zero radius acts as 1.0, scale is clamped to 1.0
  logic [RAD_W-1:0]          rad_eff_r, rad_eff_nxt;
  logic signed [SCALE_W-1:0] sc_eff_r, sc_eff_nxt;
  logic signed [CLW-1:0]     sc_w, one_w;

  always_comb begin
    rad_eff_nxt = (radius_r == '0) ? (RAD_W'(1) << FRAC_BITS) : radius_r;
    sc_w        = CLW'(scale_r);
    one_w       = CLW'(1) << FRAC_BITS;
    sc_eff_nxt  = (sc_w > one_w) ? SCALE_W'(one_w) : scale_r;
  end

  always_ff @(posedge clk) begin
    rad_eff_r <= rad_eff_nxt;
    sc_eff_r  <= sc_eff_nxt;
  end

  // --------------------------------------------------------------------------
  // pipeline enable: stops only when the output buffer is full
  // --------------------------------------------------------------------------
  logic en;
  logic sk_valid_r;

  assign en       = ~sk_valid_r;
  assign in_ready = en;

  // stage a: offsets
  logic                    va_r;
  logic signed [OFF_W-1:0] dx_a_r, dy_a_r, dx_a_nxt, dy_a_nxt;
  logic                    last_a_r;

  assign dx_a_nxt = OFF_W'(in_dest_x) - OFF_W'(origin_x_r) - OFF_W'(center_x_r);
  assign dy_a_nxt = OFF_W'(in_dest_y) - OFF_W'(origin_y_r) - OFF_W'(center_y_r);

  // stage b: squares
  logic                    vb_r;
  logic [OFF_W-1:0]        axa_full, aya_full;
  logic [MAG_W-1:0]        axa, aya;
  logic [2*MAG_W-1:0]      sqx_b_r, sqy_b_r, sqx_b_nxt, sqy_b_nxt;
  logic signed [OFF_W-1:0] dx_b_r, dy_b_r;
  logic                    last_b_r;

  assign axa_full  = dx_a_r[OFF_W-1] ? -dx_a_r : dx_a_r;
  assign aya_full  = dy_a_r[OFF_W-1] ? -dy_a_r : dy_a_r;
  assign axa       = axa_full[MAG_W-1:0];
  assign aya       = aya_full[MAG_W-1:0];
  assign sqx_b_nxt = axa * axa;
  assign sqy_b_nxt = aya * aya;

  // stage c: sum of squares
  logic                    vc_r;
  logic [SQ_W-1:0]         sq_c_r, sq_c_nxt;
  logic signed [OFF_W-1:0] dx_c_r, dy_c_r;
  logic                    last_c_r;

  assign sq_c_nxt = SQ_W'(sqx_b_r) + SQ_W'(sqy_b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_a_r   <= dx_a_nxt;
      dy_a_r   <= dy_a_nxt;
      last_a_r <= in_span_end;
      sqx_b_r  <= sqx_b_nxt;
      sqy_b_r  <= sqy_b_nxt;
      dx_b_r   <= dx_a_r;
      dy_b_r   <= dy_a_r;
      last_b_r <= last_a_r;
      sq_c_r   <= sq_c_nxt;
      dx_c_r   <= dx_b_r;
      dy_c_r   <= dy_b_r;
      last_c_r <= last_b_r;
    end
  end

  // --------------------------------------------------------------------------
  // distance
  // --------------------------------------------------------------------------
  logic            sq_valid;
  logic [RW-1:0]   sq_root;
  logic [SBW-1:0]  sq_sb;

  rdcm_sqrt #(
    .FRAC_BITS (FRAC_BITS),
    .SB_W      (SBW)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vc_r),
    .in_sq     (sq_c_r),
    .in_sb     ({dx_c_r, dy_c_r, last_c_r}),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_sb    (sq_sb)
  );

  // stage d: radius - d
  logic                   vd_r;
  logic signed [DIFW-1:0] diff_d_r, diff_d_nxt;
  logic [RW-1:0]          root_d_r;
  logic [SBW-1:0]         sb_d_r;

  assign diff_d_nxt = DIFW'(rad_eff_r) - DIFW'(sq_root);

  // stage e: scale * (radius - d)
  logic                   ve_r;
  logic signed [TW-1:0]   t_e_r, t_e_nxt;
  logic [RW-1:0]          root_e_r;
  logic [SBW-1:0]         sb_e_r;

  assign t_e_nxt = sc_eff_r * diff_d_r;

  // stage f: numerator, product truncated toward zero
  logic                   vf_r;
  logic                   tneg;
  logic [TW-1:0]          tmag;
  logic [NUMW-1:0]        tmv;
  logic [NUMW-1:0]        num_f_r, num_f_nxt;
  logic [SBW-1:0]         sb_f_r;

  assign tneg      = t_e_r[TW-1];
  assign tmag      = tneg ? -t_e_r : t_e_r;
  assign tmv       = NUMW'(tmag >> FRAC_BITS);
  assign num_f_nxt = (tneg ? -tmv : tmv) + NUMW'(root_e_r);

  // stage g: |num| * |offset| per axis
  logic                    vg_r;
  logic signed [OFF_W-1:0] dx_f, dy_f;
  logic                    last_f;
  logic [NUMW-1:0]         nmag_full;
  logic [NUMW-2:0]         nmag;
  logic [OFF_W-1:0]        axf_full, ayf_full;
  logic [MAG_W-1:0]        axf, ayf;
  logic [PW-1:0]           px_g_r, py_g_r, px_g_nxt, py_g_nxt;
  logic                    negx_g_r, negy_g_r, last_g_r;

  assign {dx_f, dy_f, last_f} = sb_f_r;
  assign nmag_full = num_f_r[NUMW-1] ? -num_f_r : num_f_r;
  assign nmag      = nmag_full[NUMW-2:0];
  assign axf_full  = dx_f[OFF_W-1] ? -dx_f : dx_f;
  assign ayf_full  = dy_f[OFF_W-1] ? -dy_f : dy_f;
  assign axf       = axf_full[MAG_W-1:0];
  assign ayf       = ayf_full[MAG_W-1:0];
  assign px_g_nxt  = nmag * axf;
  assign py_g_nxt  = nmag * ayf;

  // stage h: overflow check against radius * 2^(QUOT_W - F), divider setup
  logic                vh_r;
  logic [CMPW-1:0]     lim;
  logic                bigx_nxt, bigy_nxt;
  logic                bigx_h_r, bigy_h_r, negx_h_r, negy_h_r, last_h_r;
  logic [RAD_W-1:0]    remx_h_r, remy_h_r;
  logic [QUOT_W-1:0]   lox_h_r, loy_h_r;

  assign lim      = CMPW'(rad_eff_r) << (QUOT_W - FRAC_BITS);
  assign bigx_nxt = CMPW'(px_g_r) >= lim;
  assign bigy_nxt = CMPW'(py_g_r) >= lim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      vf_r <= 1'b0;
      vg_r <= 1'b0;
      vh_r <= 1'b0;
    end else if (en) begin
      vd_r <= sq_valid;
      ve_r <= vd_r;
      vf_r <= ve_r;
      vg_r <= vf_r;
      vh_r <= vg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff_d_r <= diff_d_nxt;
      root_d_r <= sq_root;
      sb_d_r   <= sq_sb;
      t_e_r    <= t_e_nxt;
      root_e_r <= root_d_r;
      sb_e_r   <= sb_d_r;
      num_f_r  <= num_f_nxt;
      sb_f_r   <= sb_e_r;
      px_g_r   <= px_g_nxt;
      py_g_r   <= py_g_nxt;
      negx_g_r <= num_f_r[NUMW-1] ^ dx_f[OFF_W-1];
      negy_g_r <= num_f_r[NUMW-1] ^ dy_f[OFF_W-1];
      last_g_r <= last_f;
      bigx_h_r <= bigx_nxt;
      bigy_h_r <= bigy_nxt;
      negx_h_r <= negx_g_r;
      negy_h_r <= negy_g_r;
      last_h_r <= last_g_r;
      remx_h_r <= RAD_W'(px_g_r >> (QUOT_W - FRAC_BITS));
      remy_h_r <= RAD_W'(py_g_r >> (QUOT_W - FRAC_BITS));
      lox_h_r  <= QUOT_W'({px_g_r, {FRAC_BITS{1'b0}}});
      loy_h_r  <= QUOT_W'({py_g_r, {FRAC_BITS{1'b0}}});
    end
  end

  // --------------------------------------------------------------------------
  // quotients
  // --------------------------------------------------------------------------
  logic              vx, vy;
  logic [QUOT_W-1:0] qx, qy;
  logic              negx_q, bigx_q, last_q, negy_q, bigy_q;

  rdcm_div #(
    .SB_W (3)
  ) u_div_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_rad    (rad_eff_r),
    .in_valid  (vh_r),
    .in_rem    (remx_h_r),
    .in_lo     (lox_h_r),
    .in_sb     ({negx_h_r, bigx_h_r, last_h_r}),
    .out_valid (vx),
    .out_quot  (qx),
    .out_sb    ({negx_q, bigx_q, last_q})
  );

  rdcm_div #(
    .SB_W (2)
  ) u_div_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_rad    (rad_eff_r),
    .in_valid  (vh_r),
    .in_rem    (remy_h_r),
    .in_lo     (loy_h_r),
    .in_sb     ({negy_h_r, bigy_h_r}),
    .out_valid (vy),
    .out_quot  (qy),
    .out_sb    ({negy_q, bigy_q})
  );

  // sign, center offset and saturation
  function automatic logic [OUT_W-1:0] finish_coord(
    input logic [QUOT_W-1:0]         q,
    input logic                      neg,
    input logic                      big,
    input logic signed [COORD_W-1:0] ctr
  );
    logic signed [VW-1:0] qv;
    logic signed [VW-1:0] cv;
    logic signed [VW-1:0] sum;
    logic [OUT_W-1:0]     res;
    qv  = VW'(q);
    qv  = neg ? -qv : qv;
    cv  = VW'(ctr) <<< FRAC_BITS;
    sum = qv + cv;
    if (big) begin
      res = neg ? OUT_MIN : OUT_MAX;
    end else if (sum > SAT_HI) begin
      res = OUT_MAX;
    end else if (sum < SAT_LO) begin
      res = OUT_MIN;
    end else begin
      res = sum[OUT_W-1:0];
    end
    return res;
  endfunction

  logic [OUT_W-1:0] res_x, res_y;
  logic             push;

  assign res_x = finish_coord(qx, negx_q, bigx_q, center_x_r);
  assign res_y = finish_coord(qy, negy_q, bigy_q, center_y_r);
  assign push  = en & vx;

  // --------------------------------------------------------------------------
  // output register with skid entry
  // --------------------------------------------------------------------------
  logic             out_valid_r;
  logic [OUT_W-1:0] source_x_r, source_y_r, sk_x_r, sk_y_r;
  logic             last_out_r, sk_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sk_valid_r  <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= sk_valid_r | push;
      sk_valid_r  <= 1'b0;
    end else if (push) begin
      sk_valid_r  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      if (sk_valid_r) begin
        source_x_r <= sk_x_r;
        source_y_r <= sk_y_r;
        last_out_r <= sk_last_r;
      end else begin
        source_x_r <= res_x;
        source_y_r <= res_y;
        last_out_r <= last_q;
      end
    end else if (push) begin
      sk_x_r    <= res_x;
      sk_y_r    <= res_y;
      sk_last_r <= last_q;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_source_x = source_x_r;
  assign out_source_y = source_y_r;
  assign out_last_out = last_out_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    vx == vy)
    else $error("x and y quotient lanes out of step");

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    sk_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(sk_valid_r) |-> $past(out_valid_r && !out_ready))
    else $error("skid entry filled without an output stall");

  a_big_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (push && bigx_q) |-> (res_x == OUT_MAX || res_x == OUT_MIN))
    else $error("oversized quotient did not saturate");

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// radial distortion coordinate map testbench
// Drives destination pixels through the valid/ready stream under several
// register settings, predicts each source coordinate pair in 64- and 128-bit integer
// arithmetic and checks every output transaction in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int FRAC      = rdcm_pkg::FRAC_BITS_DEF;
  localparam int CFG_IDX_W = rdcm_pkg::CFG_IDX_W;
  localparam int OUT_W     = rdcm_pkg::OUT_W;
  localparam int RAD_W     = rdcm_pkg::RAD_W;
  localparam int COORD_W   = rdcm_pkg::COORD_W;
  localparam int SCALE_W   = rdcm_pkg::SCALE_W;
  localparam int QUOT_W    = rdcm_pkg::QUOT_W;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;
  localparam int DRAIN_CYCLES = 120;

  typedef struct {
    logic signed [OUT_W-1:0] src_x;
    logic signed [OUT_W-1:0] src_y;
    logic                    last;
  } coord_pair_t;

  class coord_scoreboard;
    coord_pair_t pending[$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    function void note_pixel(coord_pair_t c);
      pending.push_back(c);
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_pixel(coord_pair_t got);
      coord_pair_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected output x=%0d y=%0d", got.src_x, got.src_y));
      end else begin
        want = pending.pop_front();
        if (got.src_x !== want.src_x)
          report($sformatf("source_x got %0d want %0d", got.src_x, want.src_x));
        if (got.src_y !== want.src_y)
          report($sformatf("source_y got %0d want %0d", got.src_y, want.src_y));
        if (got.last !== want.last)
          report($sformatf("last_out got %0b want %0b", got.last, want.last));
      end
    endtask
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [RAD_W-1:0]          cfg_wdata;
  logic                      in_valid;
  logic                      in_ready;
  logic signed [COORD_W-1:0] in_dest_x;
  logic signed [COORD_W-1:0] in_dest_y;
  logic                      in_span_end;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [OUT_W-1:0]   out_source_x;
  logic signed [OUT_W-1:0]   out_source_y;
  logic                      out_last_out;

  radial_distortion_coordinate_map_core DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_dest_x    (in_dest_x),
    .in_dest_y    (in_dest_y),
    .in_span_end  (in_span_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_source_x (out_source_x),
    .out_source_y (out_source_y),
    .out_last_out (out_last_out)
  );

  coord_scoreboard sb = new();

  // register mirror
  logic signed [COORD_W-1:0] m_origin_x, m_origin_y, m_center_x, m_center_y;
  logic [RAD_W-1:0]          m_radius;
  logic signed [SCALE_W-1:0] m_scale;
  bit                        idling;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [127:0] isqrt(logic [127:0] v);
    logic [127:0] res;
    logic [127:0] b;
    res = 0;
    b = 128'd1 << 126;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [OUT_W-1:0] map_axis(longint num, longint off,
                                                       longint ctr, longint rad);
    bit           neg;
    longint       an, ao, v;
    logic [127:0] prod, quot;
    neg  = (num < 0) != (off < 0);
    an   = num < 0 ? -num : num;
    ao   = off < 0 ? -off : off;
    prod = 128'(an) * 128'(ao);
    quot = (prod << FRAC) / 128'(rad);
    if (quot >= (128'd1 << QUOT_W)) return neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
    v = neg ? -longint'(quot[63:0]) : longint'(quot[63:0]);
    v = v + ctr * (longint'(1) << FRAC);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic coord_pair_t predict_source(logic signed [COORD_W-1:0] x,
                                                 logic signed [COORD_W-1:0] y,
                                                 logic span_end);
    coord_pair_t  c;
    longint       dx, dy, rad, sc, root_d, t, tm, num, ax, ay;
    logic [127:0] sq;
    dx   = longint'(x) - longint'(m_origin_x) - longint'(m_center_x);
    dy   = longint'(y) - longint'(m_origin_y) - longint'(m_center_y);
    rad  = (m_radius == 0) ? (longint'(1) << FRAC) : longint'({32'd0, m_radius});
    sc   = longint'(m_scale);
    if (sc > (longint'(1) << FRAC)) sc = longint'(1) << FRAC;
    ax   = dx < 0 ? -dx : dx;
    ay   = dy < 0 ? -dy : dy;
    sq   = (128'(ax) * 128'(ax) + 128'(ay) * 128'(ay)) << (2 * FRAC);
    root_d = longint'(isqrt(sq));
    t    = sc * (rad - root_d);
    tm   = (t < 0 ? -t : t) >>> FRAC;
    num  = (t < 0 ? -tm : tm) + root_d;
    c.src_x = map_axis(num, dx, longint'(m_center_x), rad);
    c.src_y = map_axis(num, dy, longint'(m_center_y), rad);
    c.last  = span_end;
    return c;
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_pixel(predict_source(in_dest_x, in_dest_y, in_span_end));
  end

  always @(posedge clk) begin
    coord_pair_t got;
    if (rst_n && out_valid && out_ready) begin
      got.src_x = out_source_x;
      got.src_y = out_source_y;
      got.last  = out_last_out;
      sb.check_pixel(got);
    end
  end

  // result side backpressure
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = idling ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [RAD_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      rdcm_pkg::REG_ORIGIN_X: m_origin_x = val[15:0];
      rdcm_pkg::REG_ORIGIN_Y: m_origin_y = val[15:0];
      rdcm_pkg::REG_CENTER_X: m_center_x = val[15:0];
      rdcm_pkg::REG_CENTER_Y: m_center_y = val[15:0];
      rdcm_pkg::REG_RADIUS:   m_radius   = val;
      rdcm_pkg::REG_SCALE:    m_scale    = val[17:0];
      default: ;
    endcase
  endtask

  task send_pixel(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                  logic span_end);
    int gap;
    gap = idling ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_dest_x   <= x;
    in_dest_y   <= y;
    in_span_end <= span_end;
    do @(posedge clk); while (!in_ready);
  endtask

  task wait_idle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task load_config(int ox, int oy, int cx, int cy, logic [31:0] rad, int sc);
    write_reg(rdcm_pkg::REG_ORIGIN_X, 32'(ox));
    write_reg(rdcm_pkg::REG_ORIGIN_Y, 32'(oy));
    write_reg(rdcm_pkg::REG_CENTER_X, 32'(cx));
    write_reg(rdcm_pkg::REG_CENTER_Y, 32'(cy));
    write_reg(rdcm_pkg::REG_RADIUS, rad);
    write_reg(rdcm_pkg::REG_SCALE, 32'(sc));
  endtask

  // mostly pixels within a few radii of the center, some anywhere
  task random_pixels(int n);
    int x, y, reach;
    reach = (m_radius >> FRAC) * 3 + 8;
    if (reach > 30000) reach = 30000;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        x = $urandom();
        y = $urandom();
      end else begin
        x = m_origin_x + m_center_x + $urandom_range(0, 2 * reach) - reach;
        y = m_origin_y + m_center_y + $urandom_range(0, 2 * reach) - reach;
      end
      send_pixel(x[15:0], y[15:0], 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    in_dest_x   = '0;
    in_dest_y   = '0;
    in_span_end = 1'b0;
    idling      = 1'b1;
    m_origin_x  = 0;
    m_origin_y  = 0;
    m_center_x  = 0;
    m_center_y  = 0;
    m_radius    = 32'h0001_0000;
    m_scale     = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, field extremes, zero offset, span flag
    send_pixel(16'sh0000, 16'sh0000, 1'b0);
    send_pixel(16'sh7fff, 16'sh7fff, 1'b1);
    send_pixel(16'sh8000, 16'sh8000, 1'b0);
    send_pixel(16'sh7fff, 16'sh8000, 1'b1);
    send_pixel(16'sh8000, 16'sh7fff, 1'b0);
    send_pixel(16'sh0001, 16'shffff, 1'b1);
    wait_idle();
    // zero radius acts as one, scale above one clamps, unused indexes ignored
    load_config(5, -3, 10, 20, 32'd0, 32'h1_ffff);
    write_reg(REG_UNUSED_6, 32'hffff_ffff);
    write_reg(REG_UNUSED_7, 32'h1234_5678);
    send_pixel(16'sd15, 16'sd17, 1'b1);
    send_pixel(16'sd16, 16'sd17, 1'b0);
    send_pixel(16'sd100, 16'sd17, 1'b1);
    send_pixel(16'sh7fff, 16'sh8000, 1'b0);
    wait_idle();
    // most negative scale, extreme registers
    load_config(-32768, 32767, 32767, -32768, 32'hffff_ffff, -131072);
    send_pixel(16'sh7fff, 16'sh7fff, 1'b1);
    send_pixel(16'sh8000, 16'sh8000, 1'b0);
    send_pixel(16'sh0000, 16'shffff, 1'b1);
    wait_idle();
    load_config(32767, -32768, -32768, 32767, 32'd1, 65536);
    send_pixel(16'sh7fff, 16'sh8000, 1'b1);
    send_pixel(16'sh8000, 16'sh7fff, 1'b0);
    send_pixel(16'sh1234, 16'sh4321, 1'b1);
    send_pixel(16'sh7fff, 16'sh0000, 1'b0);
    wait_idle();

    for (int ph = 0; ph < 9; ph++) begin
      idling = (ph % 3) != 2;
      case (ph)
        0: load_config(0, 0, 0, 0, 32'h0001_0000, 0);
        1: load_config(100, 50, 320, 240, 32'd200 << FRAC, 32'h0_8000);
        2: load_config(-20, 7, 64, -64, 32'd50 << FRAC, -131072);
        3: load_config(0, 0, 0, 0, 32'd0, 65536);
        4: load_config(3, -3, 1000, 1000, 32'hffff_ffff, 32'h1_2345);
        5: load_config(0, 0, 10, 10, 32'd1, 32'sh3_0000);
        default: load_config($urandom(), $urandom(), $urandom_range(0, 2000) - 1000,
                             $urandom_range(0, 2000) - 1000,
                             $urandom_range(1, 400) << FRAC | $urandom_range(0, 65535),
                             $urandom_range(0, 196607) - 131072);
      endcase
      random_pixels(145);
      wait_idle();
    end

    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
